[hw/rtl/pwmc_pkg.sv]
// ----------------------------------------------------------------------------
// PWM period and duty calculator: shared types and constants
// Field widths, action and waveform codes, prescaler table and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
package pwmc_pkg;

	// Field widths
	localparam int unsigned CLK_W     = 25;  // timer clock in Hz
	localparam int unsigned FREQ_W    = 24;  // requested frequency in Hz
	localparam int unsigned TOP_W     = 16;  // timer TOP / compare width
	localparam int unsigned CSEL_W    = 3;   // clock-select code
	localparam int unsigned WAVE_W    = 4;   // waveform generation bits
	localparam int unsigned PCT_W     = 8;   // duty percent input
	localparam int unsigned PCTC_W    = 7;   // duty percent after clamp to 100
	localparam int unsigned PROD_W    = 23;  // 100 * 65535 fits in 23 bits
	localparam int unsigned PRE_IDX_W = 3;   // prescaler trial index
	localparam int unsigned SHIFT_W   = 4;   // log2 of prescaler, plus one
	localparam int unsigned RECIP_W   = 24;  // reciprocal of 100
	localparam int unsigned RECIP_SH  = 30;  // exact for products below 2^23

	// Constants
	localparam logic [CLK_W-1:0]     CLK_HZ_RESET = 25'd16000000;
	localparam logic [TOP_W-1:0]     TOP_MAX      = 16'hFFFF;
	localparam logic [PCT_W-1:0]     PCT_MAX      = 8'd100;
	localparam logic [PRE_IDX_W-1:0] PRE_LAST     = 3'd4;
	localparam logic [CSEL_W-1:0]    CSEL_NONE    = 3'd0;
	localparam logic [CSEL_W-1:0]    CSEL_MAX     = 3'd5;
	localparam logic [RECIP_W-1:0]   PCT_RECIP    = 24'd10737419; // ceil(2^30 / 100)

	// Waveform select inputs and generated codes
	localparam logic [1:0] WSEL_FAST  = 2'd0;
	localparam logic [1:0] WSEL_PHASE = 2'd1;

	localparam logic [WAVE_W-1:0] WAVE_NONE  = 4'd0;
	localparam logic [WAVE_W-1:0] WAVE_FAST  = 4'd14;
	localparam logic [WAVE_W-1:0] WAVE_PHASE = 4'd10;
	localparam logic [WAVE_W-1:0] WAVE_PFC   = 4'd8;

	typedef enum logic [1:0] {
		ACT_SET_FREQ = 2'd0,
		ACT_DUTY_PCT = 2'd1,
		ACT_DUTY_RAW = 2'd2,
		ACT_READ_TOP = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV_WAIT,
		ST_TRIAL,
		ST_FINISH
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;        // capture the accepted transaction
		logic div_start;   // launch the serial divider
		logic trial_step;  // evaluate one prescaler candidate
		logic commit;      // update stored timing and present the result
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		action_t action;     // captured action
		logic    div_done;   // divider quotient ready (one-cycle pulse)
		logic    trial_done; // candidate fits, or last prescaler tried
	} dp_status_t;

	// Prescalers 1, 8, 64, 256, 1024 as right shifts
	function automatic logic [SHIFT_W-1:0] pre_shift(input logic [PRE_IDX_W-1:0] idx);
		logic [SHIFT_W-1:0] s;
		case (idx)
			3'd0:    s = 4'd0;
			3'd1:    s = 4'd3;
			3'd2:    s = 4'd6;
			3'd3:    s = 4'd8;
			default: s = 4'd10;
		endcase
		return s;
	endfunction

endpackage

[hw/rtl/pwm_period_and_duty_calc.sv]
// ----------------------------------------------------------------------------
// PWM period and duty calculator, top level
// Works out 16-bit timer prescaler, TOP and waveform code from a requested
// frequency, and compare values from a percent or raw duty.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the result is ready. Each command gives one result, shown for exactly
// one cycle with done high; the receiver cannot stall it, so it must take the
// result in that cycle. A new command may be started in the done cycle.
// A set frequency command runs the 25-step serial divider (clock /
// frequency) and then tries the prescalers in turn until one fits; duty
// percent, raw duty and read top skip both. The
// clock register is written through the cfg channel, which is always ready;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_calc
	import pwmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Command channel
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        action,
	input  logic [FREQ_W-1:0] frequency_hz,
	input  logic [1:0]        waveform_select,
	input  logic              channel,
	input  logic [PCT_W-1:0]  duty_percent,
	input  logic [TOP_W-1:0]  raw_compare,
	// Result channel
	output logic              done,
	output logic [1:0]        result_kind,
	output logic [CSEL_W-1:0] clock_select,
	output logic [TOP_W-1:0]  period_top,
	output logic [WAVE_W-1:0] waveform_code,
	output logic              compare_channel,
	output logic [TOP_W-1:0]  compare_value,
	// Configuration channel: timer clock in Hz
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CLK_W-1:0]  cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	pwmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	pwmc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.action          (action),
		.frequency_hz    (frequency_hz),
		.waveform_select (waveform_select),
		.channel         (channel),
		.duty_percent    (duty_percent),
		.raw_compare     (raw_compare),
		.done            (done),
		.result_kind     (result_kind),
		.clock_select    (clock_select),
		.period_top      (period_top),
		.waveform_code   (waveform_code),
		.compare_channel (compare_channel),
		.compare_value   (compare_value)
	);

endmodule

[hw/rtl/pwmc_div.sv]
// ----------------------------------------------------------------------------
// PWM calculator serial divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pwmc_div
	import pwmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CLK_W-1:0]  dividend,
	input  logic [FREQ_W-1:0] divisor,
	output logic              done,
	output logic [CLK_W-1:0]  quotient
);

	localparam int unsigned CNT_W = $clog2(CLK_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_W - 1);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FREQ_W-1:0] rem_q;
	logic [FREQ_W-1:0] dsr_q;
	logic [CLK_W-1:0]  quo_q;

	logic [FREQ_W:0]   trial;
	logic [FREQ_W:0]   diff;
	logic              ge;

	// One restoring step: shift in the next dividend bit and try a subtract
	always_comb begin
		trial = {rem_q, quo_q[CLK_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	// Control: run flag, step counter, completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Data: remainder, quotient/dividend shift register, held divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/pwmc_dp.sv]
// ----------------------------------------------------------------------------
// PWM calculator datapath
// Stored timing, clock register, captured transaction, prescaler trials,
// duty computation and the result registers.
// ----------------------------------------------------------------------------
module pwmc_dp
	import pwmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	input  logic              cfg_we,
	input  logic [CLK_W-1:0]  cfg_data,
	input  logic [1:0]        action,
	input  logic [FREQ_W-1:0] frequency_hz,
	input  logic [1:0]        waveform_select,
	input  logic              channel,
	input  logic [PCT_W-1:0]  duty_percent,
	input  logic [TOP_W-1:0]  raw_compare,
	output logic              done,
	output logic [1:0]        result_kind,
	output logic [CSEL_W-1:0] clock_select,
	output logic [TOP_W-1:0]  period_top,
	output logic [WAVE_W-1:0] waveform_code,
	output logic              compare_channel,
	output logic [TOP_W-1:0]  compare_value
);

	localparam int unsigned MUL_W = RECIP_SH + TOP_W;

	// Stored timing and clock register
	logic [CLK_W-1:0]     clk_hz_q;
	logic [TOP_W-1:0]     top_q;
	logic [CSEL_W-1:0]    csel_q;
	logic [WAVE_W-1:0]    wave_q;

	// Captured transaction
	action_t              act_q;
	logic                 fast_q;
	logic [WAVE_W-1:0]    wave_new_q;
	logic                 ch_q;
	logic [TOP_W-1:0]     raw_q;
	logic [FREQ_W-1:0]    freq_q;
	logic [PROD_W-1:0]    prod_q;

	// Prescaler search
	logic [PRE_IDX_W-1:0] idx_q;
	logic [TOP_W-1:0]     new_top_q;
	logic [CSEL_W-1:0]    new_csel_q;

	// Result registers
	logic                 done_q;
	logic [1:0]           res_kind_q;
	logic [CSEL_W-1:0]    res_csel_q;
	logic [TOP_W-1:0]     res_top_q;
	logic [WAVE_W-1:0]    res_wave_q;
	logic                 res_ch_q;
	logic [TOP_W-1:0]     res_val_q;

	logic [PCTC_W-1:0]    pct_clamp;
	logic [WAVE_W-1:0]    wave_sel;
	logic                 is_set;
	logic                 div_done;
	logic [CLK_W-1:0]     quotient;
	logic [SHIFT_W-1:0]   shift;
	logic [CLK_W-1:0]     q_sh;
	logic [CLK_W-1:0]     cand;
	logic                 fits;
	logic                 last;
	logic [MUL_W-1:0]     pct_full;
	logic [TOP_W-1:0]     pct_quot;

	logic [CSEL_W-1:0]    c_csel;
	logic [TOP_W-1:0]     c_top;
	logic [WAVE_W-1:0]    c_wave;
	logic                 c_ch;
	logic [TOP_W-1:0]     c_val;

	// Input decode at accept
	always_comb begin
		pct_clamp = (duty_percent > PCT_MAX) ? PCTC_W'(PCT_MAX) : duty_percent[PCTC_W-1:0];
		if (waveform_select == WSEL_FAST) begin
			wave_sel = WAVE_FAST;
		end else if (waveform_select == WSEL_PHASE) begin
			wave_sel = WAVE_PHASE;
		end else begin
			wave_sel = WAVE_PFC;
		end
	end

	// Divider works out clock / f for a set
	assign is_set = (act_q == ACT_SET_FREQ);

	pwmc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (clk_hz_q),
		.divisor  (freq_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Percent product / 100 by reciprocal multiply; the true product stays below 2^46
	assign pct_full = MUL_W'(prod_q) * MUL_W'(PCT_RECIP);
	assign pct_quot = pct_full[MUL_W-1:RECIP_SH];

	// Prescaler candidate: clk/(N*f) is (clk/f) >> log2(N), one more for phase modes
	always_comb begin
		shift = pre_shift(idx_q) + (fast_q ? SHIFT_W'(0) : SHIFT_W'(1));
		q_sh  = quotient >> shift;
		cand  = (fast_q && (q_sh != '0)) ? (q_sh - 1'b1) : q_sh;
		fits  = (cand[CLK_W-1:TOP_W] == '0);
		last  = (idx_q == PRE_LAST);
	end

	assign status.action     = act_q;
	assign status.div_done   = div_done;
	assign status.trial_done = fits || last;

	// Result values at commit
	always_comb begin
		c_csel = csel_q;
		c_top  = top_q;
		c_wave = wave_q;
		c_ch   = 1'b0;
		c_val  = '0;
		case (act_q)
			ACT_SET_FREQ: begin
				c_csel = new_csel_q;
				c_top  = new_top_q;
				c_wave = wave_new_q;
			end
			ACT_DUTY_PCT: begin
				c_ch  = ch_q;
				c_val = pct_quot;
			end
			ACT_DUTY_RAW: begin
				c_ch  = ch_q;
				c_val = (raw_q > top_q) ? top_q : raw_q;
			end
			default: begin
				c_ch  = 1'b0;
				c_val = '0;
			end
		endcase
	end

	// Clock register and stored timing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_HZ_RESET;
			top_q    <= TOP_MAX;
			csel_q   <= CSEL_NONE;
			wave_q   <= WAVE_NONE;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				clk_hz_q <= cfg_data;
			end
			if (cmd.commit && is_set) begin
				top_q  <= new_top_q;
				csel_q <= new_csel_q;
				wave_q <= wave_new_q;
			end
			done_q <= cmd.commit;
		end
	end

	// Transaction capture and prescaler search
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q      <= action_t'(action);
			fast_q     <= (waveform_select == WSEL_FAST);
			wave_new_q <= wave_sel;
			ch_q       <= channel;
			raw_q      <= raw_compare;
			freq_q     <= (frequency_hz == '0) ? FREQ_W'(1) : frequency_hz;
			prod_q     <= PROD_W'(pct_clamp) * PROD_W'(top_q);
			idx_q      <= '0;
		end else if (cmd.trial_step) begin
			if (fits) begin
				new_top_q  <= (cand[TOP_W-1:0] == '0) ? TOP_W'(1) : cand[TOP_W-1:0];
				new_csel_q <= CSEL_W'(idx_q) + 1'b1;
			end else if (last) begin
				new_top_q  <= TOP_MAX;
				new_csel_q <= CSEL_MAX;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_kind_q <= act_q;
			res_csel_q <= c_csel;
			res_top_q  <= c_top;
			res_wave_q <= c_wave;
			res_ch_q   <= c_ch;
			res_val_q  <= c_val;
		end
	end

	assign done            = done_q;
	assign result_kind     = res_kind_q;
	assign clock_select    = res_csel_q;
	assign period_top      = res_top_q;
	assign waveform_code   = res_wave_q;
	assign compare_channel = res_ch_q;
	assign compare_value   = res_val_q;

endmodule

[hw/rtl/pwmc_ctrl.sv]
// ----------------------------------------------------------------------------
// PWM calculator controller
// Sequences capture, division, prescaler trials and commit.
// ----------------------------------------------------------------------------
module pwmc_ctrl
	import pwmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output dp_cmd_t    cmd,
	input  dp_status_t status
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.action == ACT_SET_FREQ) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV_WAIT;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					state_d = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				cmd.trial_step = 1'b1;
				if (status.trial_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[tb/pwm_period_and_duty_calc_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM period and duty calculator: result checker
// Watches the command, result and clock-register channels. It keeps its own
// copy of the stored timing and compare values, works out the result of every
// accepted transaction, and compares each result as it appears.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_calc_chk
	import pwmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Command channel
	input  logic              start,
	input  logic              busy,
	input  logic [1:0]        action,
	input  logic [FREQ_W-1:0] frequency_hz,
	input  logic [1:0]        waveform_select,
	input  logic              channel,
	input  logic [PCT_W-1:0]  duty_percent,
	input  logic [TOP_W-1:0]  raw_compare,
	// Result channel
	input  logic              done,
	input  logic [1:0]        result_kind,
	input  logic [CSEL_W-1:0] clock_select,
	input  logic [TOP_W-1:0]  period_top,
	input  logic [WAVE_W-1:0] waveform_code,
	input  logic              compare_channel,
	input  logic [TOP_W-1:0]  compare_value,
	// Clock register channel
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [CLK_W-1:0]  cfg_data,
	// To the testbench top
	output int                fail_count,
	output int                outstanding
);

	typedef struct packed {
		logic [1:0]        kind;
		logic [CSEL_W-1:0] csel;
		logic [TOP_W-1:0]  top;
		logic [WAVE_W-1:0] wave;
		logic              ch;
		logic [TOP_W-1:0]  val;
	} pwm_result_t;

	localparam int unsigned MAX_REPORTS  = 10;
	localparam int unsigned PRESCALE_CNT = 5;
	localparam int unsigned PHASE_FACTOR = 2;
	localparam longint unsigned PRESCALE_DIV [PRESCALE_CNT] = '{1, 8, 64, 256, 1024};
	localparam logic [CSEL_W-1:0] PRESCALE_CSEL [PRESCALE_CNT] =
		'{3'd1, 3'd2, 3'd3, 3'd4, CSEL_MAX};

	// Shadow of the block's register and state
	logic [CLK_W-1:0]  timer_clk_hz;
	logic [TOP_W-1:0]  top_q;
	logic [CSEL_W-1:0] csel_q;
	logic [WAVE_W-1:0] wave_q;
	logic [TOP_W-1:0]  compare_q [2];

	pwm_result_t expected_results [$];
	int          errors;

	// Apply one command to the shadow state and return the result it gives
	function automatic pwm_result_t apply_command(input action_t act,
			input logic [FREQ_W-1:0] freq, input logic [1:0] wsel, input logic ch,
			input logic [PCT_W-1:0] pct, input logic [TOP_W-1:0] raw);
		pwm_result_t     r;
		longint unsigned f;
		longint unsigned divisor;
		longint unsigned quot;
		longint unsigned new_top;
		logic [CSEL_W-1:0] new_csel;
		logic            found;
		logic [PCT_W-1:0] pct_c;
		logic [TOP_W-1:0] dv;
		logic            out_ch;

		dv     = '0;
		out_ch = 1'b0;
		case (act)
			ACT_SET_FREQ: begin
				// zero frequency counts as 1 Hz
				f        = (freq == '0) ? 1 : longint'(freq);
				new_csel = CSEL_MAX;
				new_top  = longint'(TOP_MAX);
				found    = 1'b0;
				// first prescaler whose TOP fits wins; phase modes double the divisor
				for (int i = 0; i < PRESCALE_CNT; i++) begin
					if (!found) begin
						divisor = PRESCALE_DIV[i] * f;
						if (wsel != WSEL_FAST)
							divisor = divisor * PHASE_FACTOR;
						quot = longint'(timer_clk_hz) / divisor;
						if (wsel == WSEL_FAST && quot != 0)
							quot = quot - 1;
						if (quot <= longint'(TOP_MAX)) begin
							found    = 1'b1;
							new_csel = PRESCALE_CSEL[i];
							new_top  = quot;
						end
					end
				end
				if (new_top == 0)
					new_top = 1;
				top_q  = new_top[TOP_W-1:0];
				csel_q = new_csel;
				case (wsel)
					WSEL_FAST:  wave_q = WAVE_FAST;
					WSEL_PHASE: wave_q = WAVE_PHASE;
					default:    wave_q = WAVE_PFC;
				endcase
				compare_q[0] = '0;
				compare_q[1] = '0;
			end
			ACT_DUTY_PCT: begin
				pct_c = (pct > PCT_MAX) ? PCT_MAX : pct;
				dv = TOP_W'((longint'(pct_c) * longint'(top_q)) / longint'(PCT_MAX));
				compare_q[ch] = dv;
				out_ch = ch;
			end
			ACT_DUTY_RAW: begin
				dv = (raw > top_q) ? top_q : raw;
				compare_q[ch] = dv;
				out_ch = ch;
			end
			default: ; // read top: nothing changes
		endcase
		r.kind = act;
		r.csel = csel_q;
		r.top  = top_q;
		r.wave = wave_q;
		r.ch   = out_ch;
		r.val  = dv;
		return r;
	endfunction

	task automatic report(input string what, input pwm_result_t want, input pwm_result_t got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%0t: %s: expected kind %0d csel %0d top %0d wave %0d ch %0d val %0d, got kind %0d csel %0d top %0d wave %0d ch %0d val %0d",
				$realtime, what, want.kind, want.csel, want.top, want.wave, want.ch, want.val,
				got.kind, got.csel, got.top, got.wave, got.ch, got.val);
	endtask

	// Sample all channels at the rising edge: results first, then register, then commands
	always @(posedge clk or negedge arst_n) begin
		pwm_result_t want;
		pwm_result_t got;

		if (!arst_n) begin
			timer_clk_hz = CLK_HZ_RESET;
			top_q        = TOP_MAX;
			csel_q       = CSEL_NONE;
			wave_q       = WAVE_NONE;
			compare_q[0] = '0;
			compare_q[1] = '0;
			expected_results.delete();
			errors       = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				got = '{result_kind, clock_select, period_top, waveform_code,
					compare_channel, compare_value};
				if (expected_results.size() == 0) begin
					report("result with no transaction pending", '0, got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want)
						report("result mismatch", want, got);
				end
			end
			if (cfg_valid && cfg_ready)
				timer_clk_hz = cfg_data;
			if (start && !busy)
				expected_results.push_back(apply_command(action_t'(action), frequency_hz,
					waveform_select, channel, duty_percent, raw_compare));
			fail_count  <= errors;
			outstanding <= expected_results.size();
		end
	end

endmodule

[tb/pwm_period_and_duty_calc_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PWM period and duty calculator: testbench top
// Drives directed and random command transactions under several timer clock
// settings and sender gap rates; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_calc_tb
	import pwmc_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned SEGMENTS     = 6;
	localparam int unsigned SEG_ITEMS    = 330;
	localparam logic [CLK_W-1:0] CLOCK_MIN = 25'd1000000;
	localparam logic [CLK_W-1:0] CLOCK_MAX = 25'd33554431;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        action;
	logic [FREQ_W-1:0] frequency_hz;
	logic [1:0]        waveform_select;
	logic              channel;
	logic [PCT_W-1:0]  duty_percent;
	logic [TOP_W-1:0]  raw_compare;
	logic              done;
	logic [1:0]        result_kind;
	logic [CSEL_W-1:0] clock_select;
	logic [TOP_W-1:0]  period_top;
	logic [WAVE_W-1:0] waveform_code;
	logic              compare_channel;
	logic [TOP_W-1:0]  compare_value;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CLK_W-1:0]  cfg_data;

	int          fail_count;
	int          outstanding;
	int unsigned cycles;
	int unsigned gap_pct;

	pwm_period_and_duty_calc uut (.*);

	pwm_period_and_duty_calc_chk checker_i (.*);

	// 12 ns clock
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// One command transaction: random gap, then hold start until accepted
	task automatic issue(input action_t act, input logic [FREQ_W-1:0] f,
			input logic [1:0] ws, input logic ch, input logic [PCT_W-1:0] pct,
			input logic [TOP_W-1:0] raw);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) >= gap_pct)
				break;
			start = 1'b0;
		end
		start           = 1'b1;
		action          = act;
		frequency_hz    = f;
		waveform_select = ws;
		channel         = ch;
		duty_percent    = pct;
		raw_compare     = raw;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Random command: log-spread frequencies and raw values reach every prescaler
	task automatic send_random_command();
		action_t           act;
		int unsigned       pick;
		logic [FREQ_W-1:0] f;
		logic [PCT_W-1:0]  pct;
		logic [TOP_W-1:0]  raw;

		pick = $urandom_range(0, 99);
		if (pick < 30)
			act = ACT_SET_FREQ;
		else if (pick < 60)
			act = ACT_DUTY_PCT;
		else if (pick < 85)
			act = ACT_DUTY_RAW;
		else
			act = ACT_READ_TOP;
		if ($urandom_range(0, 3) == 0)
			f = FREQ_W'($urandom);
		else
			f = FREQ_W'($urandom_range(0, (1 << $urandom_range(0, FREQ_W)) - 1));
		if ($urandom_range(0, 1) == 1)
			pct = PCT_W'($urandom_range(0, PCT_MAX));
		else
			pct = PCT_W'($urandom);
		if ($urandom_range(0, 1) == 1)
			raw = TOP_W'($urandom);
		else
			raw = TOP_W'($urandom_range(0, (1 << $urandom_range(0, TOP_W)) - 1));
		issue(act, f, 2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)), pct, raw);
	endtask

	// Clock register write, only once every result is back
	task automatic write_clock(input logic [CLK_W-1:0] hz);
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = hz;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [CLK_W-1:0] hz;

		gap_pct         = 11;
		arst_n          = 1'b0;
		start           = 1'b0;
		action          = ACT_READ_TOP;
		frequency_hz    = '0;
		waveform_select = WSEL_FAST;
		channel         = 1'b0;
		duty_percent    = '0;
		raw_compare     = '0;
		cfg_valid       = 1'b0;
		cfg_data        = CLK_HZ_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset clock, reads and duty before any set, TOP edge cases
		issue(ACT_READ_TOP, '0, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_DUTY_PCT, '0, WSEL_FAST, 1'b0, 8'd50, '0);
		issue(ACT_DUTY_RAW, '0, WSEL_FAST, 1'b1, '0, 16'hFFFF);
		issue(ACT_SET_FREQ, '0, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_SET_FREQ, 24'hFFFFFF, WSEL_FAST, 1'b1, 8'hFF, 16'hFFFF);
		issue(ACT_SET_FREQ, 24'd10000000, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_SET_FREQ, 24'd1, WSEL_PHASE, 1'b0, '0, '0);
		issue(ACT_DUTY_PCT, '0, WSEL_FAST, 1'b1, 8'hFF, '0);
		issue(ACT_DUTY_PCT, '0, WSEL_FAST, 1'b0, PCT_MAX, '0);
		issue(ACT_DUTY_PCT, '0, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_DUTY_RAW, '0, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_DUTY_RAW, '0, WSEL_FAST, 1'b1, '0, 16'hFFFF);
		issue(ACT_SET_FREQ, 24'hFFFFFF, 2'd2, 1'b0, '0, '0);
		// select 3 behaves as phase and frequency correct
		issue(ACT_SET_FREQ, 24'd50, 2'd3, 1'b0, '0, '0);
		issue(ACT_READ_TOP, 24'hFFFFFF, 2'd3, 1'b1, 8'hFF, 16'hFFFF);
		issue(ACT_SET_FREQ, 24'd1000, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_DUTY_PCT, '0, WSEL_FAST, 1'b1, 8'd37, '0);

		// Directed: clock extremes
		write_clock(CLOCK_MAX);
		issue(ACT_SET_FREQ, '0, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_SET_FREQ, 24'd1, 2'd2, 1'b0, '0, '0);
		issue(ACT_DUTY_RAW, '0, WSEL_FAST, 1'b1, '0, 16'd40000);
		write_clock(CLOCK_MIN);
		issue(ACT_SET_FREQ, 24'd16, WSEL_FAST, 1'b0, '0, '0);
		issue(ACT_SET_FREQ, 24'hFFFFFF, WSEL_PHASE, 1'b0, '0, '0);
		issue(ACT_DUTY_PCT, '0, WSEL_FAST, 1'b1, 8'd99, '0);

		// Random segments: light gaps, heavy gaps, then back to back
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0:       hz = CLOCK_MIN;
				1:       hz = CLOCK_MAX;
				3:       hz = CLK_HZ_RESET;
				default: hz = CLK_W'($urandom_range(CLOCK_MIN, CLOCK_MAX));
			endcase
			write_clock(hz);
			if (seg < 2)
				gap_pct = 11;
			else if (seg < 4)
				gap_pct = 73;
			else
				gap_pct = 0;
			repeat (SEG_ITEMS) send_random_command();
		end

		// Drain
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[files.f]
hw/rtl/pwmc_pkg.sv
hw/rtl/pwmc_div.sv
hw/rtl/pwmc_dp.sv
hw/rtl/pwmc_ctrl.sv
hw/rtl/pwm_period_and_duty_calc.sv
tb/pwm_period_and_duty_calc_chk.sv
tb/pwm_period_and_duty_calc_tb.sv
